>>> sv/baf_pkg.sv
// Shared constants and register codes for the box average filter.
package baf_pkg;

   // Field widths
   localparam int PIXEL_W    = 8;
   localparam int AVG_W      = 8;
   localparam int FW_W       = 11;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 11;

   // Internal datapath widths
   localparam int CSUM_W   = 12;
   localparam int FULL_W   = 13;
   localparam int TOTAL_W  = 16;
   localparam int ROWS_W   = 4;

   // Rows-seen counter saturates here
   localparam logic [ROWS_W-1:0] ROWS_MAX = 4'd15;

   // Window sizes
   localparam int K_SMALL = 7;
   localparam int K_LARGE = 15;

   // Register reset values
   localparam int RESET_FRAME_WIDTH = 640;

   // Reciprocal divide: floor(x / d) = (x * ceil(2^s / d)) >> s for 16-bit x
   localparam int RECIP_SHIFT = 24;
   localparam int RECIP_W     = 19;

   // Result queue depth
   localparam int OUT_DEPTH = 4;

   // Register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FRAME_WIDTH = 2'd0,
      CSR_WINDOW_MODE = 2'd1
   } csr_index_type;

endpackage

>>> sv/baf_if.sv
// Handshake interfaces for the pixel, result and register write channels.
interface baf_req_if;
   import baf_pkg::*;
   logic               valid;
   logic               ready;
   logic [PIXEL_W-1:0] pixel;
   logic               frame_start;

   modport source (output valid, output pixel, output frame_start, input ready);
   modport sink   (input valid, input pixel, input frame_start, output ready);
endinterface

interface baf_rsp_if;
   import baf_pkg::*;
   logic             valid;
   logic             ready;
   logic [AVG_W-1:0] average;

   modport source (output valid, output average, input ready);
   modport sink   (input valid, input average, output ready);
endinterface

interface baf_csr_if;
   import baf_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

>>> sv/box_average_filter_unit.sv
// Box average filter: for each raster-order pixel, the floor mean of the 7x7 or 15x15
// window whose bottom-right corner is that pixel, with positions outside the frame as
// zero (shift by (K-1)/2 for a centered mean). One pixel is taken every clock while the
// result queue has room; results pass the update and divide stages into the queue. The
// per-column sums and the line store live in two RAMs that are read in the cycle a pixel
// is taken and written back the next cycle; the read-modify-write of the column-sum RAM
// sets that rate, with a forwarding path when back-to-back pixels hit the same column.
// A four-word result queue lets pixels keep flowing while results wait on rsp. The RAMs
// need no clearing pass: every entry is written in the current frame before it counts.
// frame_width and window_mode take effect at the next pixel with frame_start set.
module box_average_filter_unit #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_WINDOW = 15
) (
   input logic        clock,
   input logic        reset,
   baf_req_if.sink    req_port,
   baf_rsp_if.source  rsp_port,
   baf_csr_if.sink    csr_port
);

   import baf_pkg::*;

   localparam int COL_W       = $clog2(MAX_WIDTH);
   localparam int WID_W       = COL_W + 1;
   localparam int LINE_ROWS   = MAX_WINDOW - 1;
   localparam int SLOT_W      = $clog2(LINE_ROWS);
   localparam int LINE_DEPTH  = LINE_ROWS << COL_W;
   localparam int K_BIG       = (K_LARGE > MAX_WINDOW) ? MAX_WINDOW : K_LARGE;
   localparam int OFF_BIG     = MAX_WINDOW - K_BIG;
   localparam int OFF_SMALL   = MAX_WINDOW - K_SMALL;
   localparam int RESET_WIDTH =
      (RESET_FRAME_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RESET_FRAME_WIDTH;
   localparam int D_BIG       = K_BIG * K_BIG;
   localparam int D_SMALL     = K_SMALL * K_SMALL;
   localparam logic [RECIP_W-1:0] RECIP_BIG =
      RECIP_W'(((1 << RECIP_SHIFT) + D_BIG - 1) / D_BIG);
   localparam logic [RECIP_W-1:0] RECIP_SMALL =
      RECIP_W'(((1 << RECIP_SHIFT) + D_SMALL - 1) / D_SMALL);
   localparam int PROD_W      = TOTAL_W + RECIP_W;
   localparam int CNT_W       = $clog2(OUT_DEPTH + 1);

   // Per-pixel control carried from the accept cycle into the update stage
   typedef struct packed {
      logic [PIXEL_W-1:0] pixel;
      logic [COL_W-1:0]   col;
      logic [SLOT_W-1:0]  slot;
      logic               above_en;
      logic               leave_en;
      logic               col_ge_k;
      logic               col_zero;
      logic               big;
   } stage_type;

   // Registers
   logic [FW_W-1:0]    frame_width_ff, frame_width_in;
   logic               window_mode_ff, window_mode_in;
   logic [WID_W-1:0]   active_width_ff, active_width_in;
   logic               active_big_ff, active_big_in;
   logic [COL_W-1:0]   col_ff, col_in;
   logic [ROWS_W-1:0]  rows_ff, rows_in;
   logic [SLOT_W-1:0]  slot_ff, slot_in;
   logic               b_valid_ff, b_valid_in;
   stage_type          b_ff, b_in;
   logic               fwd_hit_ff, fwd_hit_in;
   logic [CSUM_W-1:0]  fwd_data_ff, fwd_data_in;
   logic [TOTAL_W-1:0] wt_ff, wt_in;
   logic [CSUM_W-1:0]  taps_ff [MAX_WINDOW];
   logic [CSUM_W-1:0]  taps_in [MAX_WINDOW];
   logic               c_valid_ff, c_valid_in;
   logic [TOTAL_W-1:0] c_total_ff, c_total_in;
   logic               c_big_ff, c_big_in;

   // Accept-stage signals
   logic               req_fire;
   logic               csr_fire;
   logic [WID_W-1:0]   new_width;
   logic [WID_W-1:0]   cur_width;
   logic               cur_big;
   logic [COL_W-1:0]   cur_col;
   logic [ROWS_W-1:0]  cur_rows;
   logic [SLOT_W-1:0]  cur_slot;
   logic [SLOT_W:0]    leave_sum;
   logic [SLOT_W-1:0]  leave_slot;
   logic [ROWS_W-1:0]  k_less_one;
   logic [WID_W-1:0]   k_wide;
   logic [WID_W-1:0]   col_inc;
   logic               row_wrap;

   // Update-stage signals
   logic [CSUM_W-1:0]  cs_rd_data;
   logic [PIXEL_W-1:0] ls_rd_data;
   logic [CSUM_W-1:0]  above;
   logic [FULL_W-1:0]  full;
   logic [PIXEL_W-1:0] leaving;
   logic [CSUM_W-1:0]  cs_wr_data;
   logic [CSUM_W-1:0]  gone;
   logic [TOTAL_W-1:0] wt_next;

   // Divide stage and result queue
   logic [PROD_W-1:0]  prod;
   logic [CNT_W-1:0]   q_count;
   logic [CNT_W:0]     in_flight;

   assign req_fire = req_port.valid && req_port.ready;
   assign csr_fire = csr_port.valid && csr_port.ready;
   assign csr_port.ready = 1'b1;

   // Register writes
   always_comb begin
      frame_width_in = frame_width_ff;
      window_mode_in = window_mode_ff;
      if (csr_fire) begin
         case (csr_port.index)
            CSR_FRAME_WIDTH: frame_width_in = csr_port.data[FW_W-1:0];
            CSR_WINDOW_MODE: window_mode_in = csr_port.data[0];
            default: ;
         endcase
      end
   end

   // Width clamp applied when a frame starts
   always_comb begin
      if (frame_width_ff == '0) begin
         new_width = WID_W'(1);
      end else if (32'(frame_width_ff) > 32'(MAX_WIDTH)) begin
         new_width = WID_W'(MAX_WIDTH);
      end else begin
         new_width = WID_W'(frame_width_ff);
      end
   end

   // Accept stage: position of this pixel and read addresses
   always_comb begin
      cur_width = req_port.frame_start ? new_width      : active_width_ff;
      cur_big   = req_port.frame_start ? window_mode_ff : active_big_ff;
      cur_col   = req_port.frame_start ? '0 : col_ff;
      cur_rows  = req_port.frame_start ? '0 : rows_ff;
      cur_slot  = req_port.frame_start ? '0 : slot_ff;

      // oldest row of the window, one compare-subtract around the line ring
      leave_sum = {1'b0, cur_slot} + (cur_big ? (SLOT_W + 1)'(OFF_BIG)
                                              : (SLOT_W + 1)'(OFF_SMALL));
      if (leave_sum >= (SLOT_W + 1)'(LINE_ROWS)) begin
         leave_slot = SLOT_W'(leave_sum - (SLOT_W + 1)'(LINE_ROWS));
      end else begin
         leave_slot = leave_sum[SLOT_W-1:0];
      end

      k_less_one = cur_big ? ROWS_W'(K_BIG - 1) : ROWS_W'(K_SMALL - 1);
      k_wide     = cur_big ? WID_W'(K_BIG) : WID_W'(K_SMALL);
      col_inc    = WID_W'(cur_col) + WID_W'(1);
      row_wrap   = (col_inc >= cur_width);

      b_in.pixel    = req_port.pixel;
      b_in.col      = cur_col;
      b_in.slot     = cur_slot;
      b_in.above_en = (cur_rows != '0);
      b_in.leave_en = (cur_rows >= k_less_one);
      b_in.col_ge_k = (WID_W'(cur_col) >= k_wide);
      b_in.col_zero = (cur_col == '0);
      b_in.big      = cur_big;
   end

   // Frame position counters and latched settings
   always_comb begin
      active_width_in = active_width_ff;
      active_big_in   = active_big_ff;
      col_in          = col_ff;
      rows_in         = rows_ff;
      slot_in         = slot_ff;
      if (req_fire) begin
         active_width_in = cur_width;
         active_big_in   = cur_big;
         if (row_wrap) begin
            col_in  = '0;
            rows_in = (cur_rows == ROWS_MAX) ? cur_rows : cur_rows + ROWS_W'(1);
            slot_in = (cur_slot == SLOT_W'(LINE_ROWS - 1)) ? '0
                                                           : cur_slot + SLOT_W'(1);
         end else begin
            col_in  = col_inc[COL_W-1:0];
            rows_in = cur_rows;
            slot_in = cur_slot;
         end
      end
   end

   // Column-sum forwarding when the previous pixel writes the column read now
   assign b_valid_in  = req_fire;
   assign fwd_hit_in  = b_valid_ff && (b_ff.col == cur_col);
   assign fwd_data_in = cs_wr_data;

   // Column sums: read on accept, written back in the update stage
   baf_ram #(
      .WIDTH (CSUM_W),
      .DEPTH (MAX_WIDTH)
   ) u_col_sums (
      .clock   (clock),
      .wr_en   (b_valid_ff),
      .wr_addr (b_ff.col),
      .wr_data (cs_wr_data),
      .rd_en   (req_fire),
      .rd_addr (cur_col),
      .rd_data (cs_rd_data)
   );

   // Line store: one ring row per image line, row slot above column
   baf_ram #(
      .WIDTH (PIXEL_W),
      .DEPTH (LINE_DEPTH)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (b_valid_ff),
      .wr_addr ({b_ff.slot, b_ff.col}),
      .wr_data (b_ff.pixel),
      .rd_en   (req_fire),
      .rd_addr ({leave_slot, cur_col}),
      .rd_data (ls_rd_data)
   );

   // Update stage: vertical sum, then running horizontal sum
   always_comb begin
      if (!b_ff.above_en) begin
         above = '0;
      end else if (fwd_hit_ff) begin
         above = fwd_data_ff;
      end else begin
         above = cs_rd_data;
      end
      full       = FULL_W'(above) + FULL_W'(b_ff.pixel);
      leaving    = b_ff.leave_en ? ls_rd_data : '0;
      cs_wr_data = CSUM_W'(full - FULL_W'(leaving));

      if (!b_ff.col_ge_k) begin
         gone = '0;
      end else if (b_ff.big) begin
         gone = taps_ff[K_BIG-1];
      end else begin
         gone = taps_ff[K_SMALL-1];
      end

      if (b_ff.col_zero) begin
         wt_next = TOTAL_W'(full);
      end else begin
         wt_next = wt_ff + TOTAL_W'(full) - TOTAL_W'(gone);
      end
   end

   // Recent column sums of this row as a shift line
   always_comb begin
      for (int i = 0; i < MAX_WINDOW; i++) begin
         taps_in[i] = taps_ff[i];
      end
      if (b_valid_ff) begin
         taps_in[0] = full[CSUM_W-1:0];
         for (int i = 1; i < MAX_WINDOW; i++) begin
            taps_in[i] = taps_ff[i-1];
         end
      end
   end

   assign wt_in      = b_valid_ff ? wt_next : wt_ff;
   assign c_valid_in = b_valid_ff;
   assign c_total_in = wt_next;
   assign c_big_in   = b_ff.big;

   // Divide stage: multiply by the reciprocal of K*K
   assign prod = PROD_W'(c_total_ff) * PROD_W'(c_big_ff ? RECIP_BIG : RECIP_SMALL);

   baf_out_queue #(
      .WIDTH (AVG_W),
      .DEPTH (OUT_DEPTH)
   ) u_out_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (c_valid_ff),
      .push_data (prod[RECIP_SHIFT +: AVG_W]),
      .pop_valid (rsp_port.valid),
      .pop_ready (rsp_port.ready),
      .pop_data  (rsp_port.average),
      .count     (q_count)
   );

   // Take a pixel only while its result is sure of a queue slot
   assign in_flight = (CNT_W + 1)'(q_count) + (CNT_W + 1)'(b_valid_ff)
                    + (CNT_W + 1)'(c_valid_ff);
   assign req_port.ready = (in_flight < (CNT_W + 1)'(OUT_DEPTH));

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= FW_W'(RESET_FRAME_WIDTH);
         window_mode_ff  <= 1'b0;
         active_width_ff <= WID_W'(RESET_WIDTH);
         active_big_ff   <= 1'b0;
         col_ff          <= '0;
         rows_ff         <= '0;
         slot_ff         <= '0;
         b_valid_ff      <= 1'b0;
         c_valid_ff      <= 1'b0;
         wt_ff           <= '0;
      end else begin
         frame_width_ff  <= frame_width_in;
         window_mode_ff  <= window_mode_in;
         active_width_ff <= active_width_in;
         active_big_ff   <= active_big_in;
         col_ff          <= col_in;
         rows_ff         <= rows_in;
         slot_ff         <= slot_in;
         b_valid_ff      <= b_valid_in;
         c_valid_ff      <= c_valid_in;
         wt_ff           <= wt_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      b_ff        <= b_in;
      fwd_hit_ff  <= fwd_hit_in;
      fwd_data_ff <= fwd_data_in;
      c_total_ff  <= c_total_in;
      c_big_ff    <= c_big_in;
      for (int i = 0; i < MAX_WINDOW; i++) begin
         taps_ff[i] <= taps_in[i];
      end
   end

endmodule

>>> sv/baf_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module baf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and registered read ports; a read of the address being written returns the old word
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/baf_out_queue.sv
// Small result queue between the filter pipeline and the result channel.
module baf_out_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4,
   localparam int PTR_W = $clog2(DEPTH),
   localparam int CNT_W = $clog2(DEPTH + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data,
   output logic [CNT_W-1:0] count
);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             pop;

   assign pop_valid = (count_ff != '0);
   assign pop_data  = entry_ff[rd_ptr_ff];
   assign pop       = pop_valid && pop_ready;
   assign count     = count_ff;

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> sv/baf_checker.sv
// Port-level checks for the box average filter, bound to the top level.
module baf_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic [baf_pkg::AVG_W-1:0] rsp_average
);

   import baf_pkg::*;

   logic       req_fire;
   logic       rsp_fire;
   logic [3:0] pending_ff, pending_in;

   assign req_fire = req_valid && req_ready;
   assign rsp_fire = rsp_valid && rsp_ready;

   // Words taken on req and not yet delivered on rsp
   always_comb begin
      pending_in = pending_ff;
      if (req_fire && !rsp_fire) begin
         pending_in = pending_ff + 4'd1;
      end else if (rsp_fire && !req_fire) begin
         pending_in = pending_ff - 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   // A stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_average))
      else $error("rsp word dropped or changed while stalled");

   // No result without a pixel behind it
   a_no_extra: assert property (@(posedge clock) disable iff (reset)
      rsp_fire |-> pending_ff != 4'd0)
      else $error("rsp word with no pixel outstanding");

   // Flow control keeps the pipeline within the result queue
   a_bound: assert property (@(posedge clock) disable iff (reset)
      pending_ff <= 4'(OUT_DEPTH))
      else $error("more pixels outstanding than the result queue holds");

   // From idle, a result crosses the update, divide and queue registers
   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_fire && pending_ff == 4'd0 |-> ##3 rsp_valid)
      else $error("result did not appear three cycles after its pixel");

endmodule

bind box_average_filter_unit baf_checker u_baf_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_port.valid),
   .req_ready   (req_port.ready),
   .rsp_valid   (rsp_port.valid),
   .rsp_ready   (rsp_port.ready),
   .rsp_average (rsp_port.average)
);

>>> test/tb_top.sv
// Self-checking testbench for box_average_filter_unit: streams pixels and checks each average.
module tb_top;
   import baf_pkg::*;

   localparam int MAX_WIDTH      = 1024;
   localparam int MAX_WINDOW     = 15;
   localparam int LINE_ROWS      = MAX_WINDOW - 1;
   localparam int CLOCK_PERIOD   = 8;
   localparam int SETTLE_CYCLES  = 8;
   localparam int RANDOM_ITEMS   = 600;
   localparam int TIMEOUT_CYCLES = 600000;

   // Indexes with no register behind them; writes there are dropped
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LOW  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HIGH = 2'd3;

   typedef enum {CONTENT_UNIFORM, CONTENT_BRIGHT, CONTENT_EXTREME} content_type;
   typedef enum {
      FRAME_CLEAN, FRAME_RESTART, FRAME_HELD_SETTINGS, FRAME_NOISE, FRAME_CONTINUED
   } frame_kind_type;

   logic clock;
   logic reset;

   baf_req_if req_bus ();
   baf_rsp_if rsp_bus ();
   baf_csr_if csr_bus ();

   box_average_filter_unit #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_WINDOW (MAX_WINDOW)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_bus),
      .rsp_port (rsp_bus),
      .csr_port (csr_bus)
   );

   // Expected averages, oldest first
   logic [AVG_W-1:0] pending_averages [$];
   int               fault_count = 0;
   int               pixels_sent = 0;
   bit               gaps_on     = 1'b0;
   int               rsp_hold    = 0;

   // Filter state mirrored by the predictor
   logic [PIXEL_W-1:0] line_rows [LINE_ROWS][MAX_WIDTH];
   logic [CSUM_W-1:0]  col_sums [MAX_WIDTH];
   logic [CSUM_W-1:0]  row_col_sums [MAX_WINDOW];
   logic [TOTAL_W-1:0] run_total;
   int unsigned        cur_col, rows_done, cur_slot, live_k, live_width;
   logic [FW_W-1:0]    shadow_width;
   logic               shadow_mode;

   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   initial begin
      #(CLOCK_PERIOD * TIMEOUT_CYCLES);
      $display("** box_average_filter_unit: FAILED **");
      $finish;
   end

   // Register values only take hold at a frame start
   function automatic void latch_live_settings();
      int unsigned w;
      w = shadow_width;
      if (w == 0) w = 1;
      if (w > MAX_WIDTH) w = MAX_WIDTH;
      live_width = w;
      live_k     = shadow_mode ? K_LARGE : K_SMALL;
   endfunction

   // Advance the filter state by one pixel and return its window mean
   function automatic logic [AVG_W-1:0] next_average(input logic [PIXEL_W-1:0] pix,
                                                     input logic fs);
      int unsigned col, k, above, full, out_slot, leaving, gone, total;
      if (fs) begin
         latch_live_settings();
         cur_col   = 0;
         rows_done = 0;
         cur_slot  = 0;
      end
      k   = live_k;
      col = cur_col;

      // vertical: add this pixel, drop the one K-1 rows up
      above    = (rows_done == 0) ? 0 : col_sums[col];
      full     = above + pix;
      out_slot = (cur_slot + MAX_WINDOW - k) % LINE_ROWS;
      leaving  = (rows_done >= k - 1) ? line_rows[out_slot][col] : 0;
      col_sums[col]            = CSUM_W'(full - leaving);
      line_rows[cur_slot][col] = pix;

      // horizontal: running total over the last K column sums
      gone = (col >= k) ? row_col_sums[(col + MAX_WINDOW - k) % MAX_WINDOW] : 0;
      if (col == 0) total = full;
      else total = run_total + full - gone;
      run_total = TOTAL_W'(total);
      row_col_sums[col % MAX_WINDOW] = CSUM_W'(full);

      col++;
      if (col >= live_width) begin
         col = 0;
         if (rows_done < ROWS_MAX) rows_done++;
         cur_slot = (cur_slot + 1) % LINE_ROWS;
      end
      cur_col = col;
      return AVG_W'(run_total / (k * k));
   endfunction

   function automatic logic [PIXEL_W-1:0] pick_pixel(input content_type style);
      case (style)
         CONTENT_BRIGHT:  return 8'd255;
         CONTENT_EXTREME: return ($urandom_range(0, 1) != 0) ? 8'd255 : 8'd0;
         default:         return PIXEL_W'($urandom_range(0, 255));
      endcase
   endfunction

   // One pixel word; valid stays high into the next call unless a gap is drawn
   task automatic send_pixel(input logic [PIXEL_W-1:0] pix, input logic fs);
      int gap;
      gap = gaps_on ? $urandom_range(0, 8) : 0;
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.pixel       <= pix;
      req_bus.frame_start <= fs;
      do @(posedge clock); while (!req_bus.ready);
      pending_averages.push_back(next_average(pix, fs));
      pixels_sent++;
   endtask

   task automatic send_run(input int n, input content_type style, input logic lead_fs);
      for (int i = 0; i < n; i++) send_pixel(pick_pixel(style), lead_fs && (i == 0));
   endtask

   // Stop sending and let every outstanding average come back
   task automatic wait_all_results();
      req_bus.valid <= 1'b0;
      while (pending_averages.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= value;
      do @(posedge clock); while (!csr_bus.ready);
      if (idx == CSR_FRAME_WIDTH) shadow_width = value;
      else if (idx == CSR_WINDOW_MODE) shadow_mode = value[0];
   endtask

   // Back-to-back register words, optionally with a dropped write in between
   task automatic configure(input logic [CSR_DATA_W-1:0] width_data,
                            input logic [CSR_DATA_W-1:0] mode_data,
                            input bit add_spare);
      write_reg(CSR_FRAME_WIDTH, width_data);
      if (add_spare)
         write_reg(($urandom_range(0, 1) != 0) ? CSR_SPARE_HIGH : CSR_SPARE_LOW,
                   CSR_DATA_W'($urandom_range(0, 2047)));
      write_reg(CSR_WINDOW_MODE, mode_data);
      csr_bus.valid <= 1'b0;
   endtask

   // Pixels before any frame start run on the reset settings
   task automatic test_unframed_start();
      gaps_on = 1'b0;
      send_pixel(8'd255, 1'b0);
      send_pixel(8'd255, 1'b0);
      send_pixel(8'd0, 1'b0);
      send_pixel(8'd255, 1'b0);
      send_pixel(8'd128, 1'b0);
      wait_all_results();
   endtask

   // Width 0 behaves as a single column; nine rows fill and slide the 7-row window
   task automatic test_zero_width();
      configure(11'd0, 11'd0, 1'b0);
      send_run(9, CONTENT_BRIGHT, 1'b1);
      wait_all_results();
   endtask

   // New register values wait for the next frame start; spare indexes change nothing
   task automatic test_deferred_settings();
      gaps_on = 1'b1;
      configure(11'd3, 11'd1, 1'b1);
      send_run(6, CONTENT_EXTREME, 1'b1);
      wait_all_results();
      configure(11'd1, 11'd0, 1'b1);
      send_run(4, CONTENT_BRIGHT, 1'b0);
      send_pixel(8'd255, 1'b1);
      wait_all_results();
   endtask

   // Width above the line store clamps to the maximum; 15x15 window across a full row
   task automatic test_full_width();
      gaps_on = 1'b0;
      configure(11'd2047, 11'd1, 1'b0);
      send_run(MAX_WIDTH + 16, CONTENT_UNIFORM, 1'b1);
      wait_all_results();
   endtask

   // Receiver stalls long enough to fill the result queue and block the input
   task automatic test_backpressure();
      gaps_on = 1'b0;
      configure(11'd5, 11'd0, 1'b0);
      rsp_hold = 48;
      send_run(40, CONTENT_UNIFORM, 1'b1);
      wait_all_results();
   endtask

   // Mostly well-formed frames of random size and content, plus broken ones
   task automatic test_random_frames();
      int             first_sent, w_data, width, count;
      frame_kind_type kind;
      content_type    style;
      first_sent = pixels_sent;
      while (pixels_sent - first_sent < RANDOM_ITEMS) begin
         wait_all_results();
         gaps_on = ($urandom_range(0, 3) != 0);
         case ($urandom_range(0, 9))
            0:       w_data = 0;
            1:       w_data = $urandom_range(MAX_WIDTH + 1, 2047);
            2:       w_data = $urandom_range(17, 80);
            default: w_data = $urandom_range(1, 16);
         endcase
         configure(CSR_DATA_W'(w_data), CSR_DATA_W'($urandom_range(0, 2047)),
                   $urandom_range(0, 3) == 0);
         width = (w_data == 0) ? 1 : ((w_data > MAX_WIDTH) ? MAX_WIDTH : w_data);
         count = width * $urandom_range(1, 20);
         if (count > 400) count = $urandom_range(40, 400);
         style = content_type'($urandom_range(0, 2));
         case ($urandom_range(0, 7))
            4:       kind = FRAME_RESTART;
            5:       kind = FRAME_HELD_SETTINGS;
            6:       kind = FRAME_NOISE;
            7:       kind = FRAME_CONTINUED;
            default: kind = FRAME_CLEAN;
         endcase

         case (kind)
            FRAME_RESTART: begin
               // new frame start lands halfway through the pixels, often mid-row
               send_run(count / 2, style, 1'b1);
               send_run(count - count / 2, style, 1'b1);
            end
            FRAME_HELD_SETTINGS: begin
               send_run(count / 2, style, 1'b1);
               wait_all_results();
               configure(CSR_DATA_W'($urandom_range(0, 40)),
                         CSR_DATA_W'($urandom_range(0, 2047)), 1'b0);
               send_run(count - count / 2, style, 1'b0);
            end
            FRAME_NOISE: begin
               for (int i = 0; i < count; i++)
                  send_pixel(pick_pixel(style), $urandom_range(0, 5) == 0);
            end
            FRAME_CONTINUED: send_run(count, style, 1'b0);
            default:         send_run(count, style, 1'b1);
         endcase
      end
      wait_all_results();
   endtask

   // Result ready: random stall after each word while gaps are on, or a long hold when asked
   initial begin : result_ready_driver
      int stall_left;
      stall_left    = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_hold > 0) begin
            stall_left = rsp_hold;
            rsp_hold   = 0;
         end else if (rsp_bus.valid && rsp_bus.ready && gaps_on) begin
            stall_left = $urandom_range(0, 8);
         end
         if (stall_left > 0) begin
            rsp_bus.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // Compare each result word with the oldest expectation
   always @(posedge clock) begin : result_check
      logic [AVG_W-1:0] wanted;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_averages.size() == 0) begin
            fault_count++;
            if (fault_count <= 10)
               $display("average %0d arrived with nothing pending", rsp_bus.average);
         end else begin
            wanted = pending_averages.pop_front();
            if (rsp_bus.average !== wanted) begin
               fault_count++;
               if (fault_count <= 10)
                  $display("average mismatch: expected %0d, got %0d", wanted, rsp_bus.average);
            end
         end
      end
   end

   initial begin
      reset               = 1'b1;
      req_bus.valid       = 1'b0;
      req_bus.pixel       = '0;
      req_bus.frame_start = 1'b0;
      csr_bus.valid       = 1'b0;
      csr_bus.index       = CSR_FRAME_WIDTH;
      csr_bus.data        = '0;

      // predictor starts from the reset state
      foreach (line_rows[r, c]) line_rows[r][c] = '0;
      foreach (col_sums[c]) col_sums[c] = '0;
      foreach (row_col_sums[c]) row_col_sums[c] = '0;
      run_total    = '0;
      cur_col      = 0;
      rows_done    = 0;
      cur_slot     = 0;
      shadow_width = FW_W'(RESET_FRAME_WIDTH);
      shadow_mode  = 1'b0;
      latch_live_settings();

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_unframed_start();
      test_zero_width();
      test_deferred_settings();
      test_full_width();
      test_backpressure();
      test_random_frames();

      if (fault_count == 0) $display("** box_average_filter_unit: PASSED **");
      else $display("** box_average_filter_unit: FAILED **");
      $finish;
   end

endmodule
